@@ rtl/rklc_pkg.sv @@
// shared types, constants and letter arithmetic for the running-key letter cipher
package rklc_pkg;

  localparam int unsigned BOOK_DEPTH = 1024;
  localparam int unsigned ADDR_W     = $clog2(BOOK_DEPTH);
  localparam int unsigned LEN_W      = $clog2(BOOK_DEPTH + 1);
  localparam int unsigned LTR_W      = 5;
  localparam logic [LTR_W-1:0] ALPHA_LEN = LTR_W'(26);
  localparam logic [7:0] ASCII_UC_A = 8'h41;
  localparam logic [7:0] ASCII_UC_Z = 8'h5A;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_LC_Z = 8'h7A;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_START  = 2'd2,
    MODE_TEXT   = 2'd3
  } mode_t;

  // write request into the key book
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LTR_W-1:0]  data;
  } book_wr_t;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= ASCII_UC_A) && (b <= ASCII_UC_Z);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return is_upper(b) || ((b >= ASCII_LC_A) && (b <= ASCII_LC_Z));
  endfunction

  // letter index 0..25, only meaningful for letters
  function automatic logic [LTR_W-1:0] letter_idx(input logic [7:0] b);
    logic [7:0] d;
    d = is_upper(b) ? (b - ASCII_UC_A) : (b - ASCII_LC_A);
    return d[LTR_W-1:0];
  endfunction

  // shift a letter index by a key letter, modulo the alphabet
  function automatic logic [LTR_W-1:0] shift_letter(input logic [LTR_W-1:0] p,
                                                     input logic [LTR_W-1:0] k,
                                                     input logic             dec);
    logic [LTR_W:0] s;
    s = dec ? ({1'b0, p} + {1'b0, ALPHA_LEN} - {1'b0, k}) : ({1'b0, p} + {1'b0, k});
    if (s >= {1'b0, ALPHA_LEN}) begin
      s = s - {1'b0, ALPHA_LEN};
    end
    return s[LTR_W-1:0];
  endfunction

endpackage

@@ rtl/rklc_book.sv @@
// key book memory with a prefetched, write-bypassed key letter read
module rklc_book
  import rklc_pkg::*;
(
  input  logic              clk,
  input  book_wr_t          wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [LTR_W-1:0]  key_letter
);

  logic [LTR_W-1:0] mem [BOOK_DEPTH];
  logic [LTR_W-1:0] rd_data_r;
  logic             byp_r;
  logic [LTR_W-1:0] byp_data_r;

  // book storage, one write and one read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // a letter written to the address being read wins over the old contents
  always_ff @(posedge clk) begin
    byp_r      <= wr.en && (wr.addr == rd_addr);
    byp_data_r <= wr.data;
  end

  assign key_letter = byp_r ? byp_data_r : rd_data_r;

endmodule

@@ rtl/running_key_letter_cipher_top.sv @@
// Running-key letter cipher over a byte stream. One word is accepted every cycle
// whenever the result register is free or being emptied in the same cycle; a text
// word gives its result in the cycle after acceptance, and clear, append and
// start-message words give none. The key letter for the next text word is always
// fetched ahead from the 1024-entry book memory (one write and one registered read
// port), with a bypass when the letter being appended is the one being fetched, so
// back-to-back text words run at one word per cycle unless stalled. Book entries
// need no clearing pass after reset: only entries below the loaded length are ever used.
module running_key_letter_cipher_top
  import rklc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_out,
  output logic        out_key_missing,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_START_POS = 1'b1;

  logic             direction_r;
  logic [10:0]      start_pos_r;
  logic [LEN_W-1:0] book_len_r, book_len_nxt;
  logic [ADDR_W-1:0] key_pos_r, key_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_miss_r, out_miss_nxt;
  logic [LTR_W-1:0] key_letter;
  logic             in_acc;
  logic             ch_letter;
  logic [LTR_W-1:0] ch_idx;
  logic [LTR_W-1:0] shifted;
  logic [10:0]      start_m1;
  logic [LEN_W:0]   pos_inc;
  book_wr_t         book_wr;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      start_pos_r <= 11'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DIRECTION: direction_r <= pwdata[0];
        REG_START_POS: start_pos_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_START_POS) ? {21'd0, start_pos_r} : {31'd0, direction_r};

  // handshake: the result register frees itself when taken
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_key_missing = out_miss_r;

  // letter decode and shift by the prefetched key letter
  assign ch_letter = is_letter(in_char_in);
  assign ch_idx    = letter_idx(in_char_in);
  assign shifted   = shift_letter(ch_idx, key_letter, direction_r);
  assign start_m1  = start_pos_r - 11'd1;
  assign pos_inc   = {{(LEN_W-ADDR_W+1){1'b0}}, key_pos_r} + (LEN_W+1)'(1);

  // next state for book, key position and result
  always_comb begin
    book_len_nxt  = book_len_r;
    key_pos_nxt   = key_pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_miss_nxt  = out_miss_r;
    book_wr.en    = 1'b0;
    book_wr.addr  = book_len_r[ADDR_W-1:0];
    book_wr.data  = ch_idx;
    if (in_acc) begin
      case (mode_t'(in_mode))
        MODE_CLEAR: begin
          book_len_nxt = '0;
          key_pos_nxt  = '0;
        end
        MODE_APPEND: begin
          if (ch_letter && (book_len_r < LEN_W'(BOOK_DEPTH))) begin
            book_wr.en   = 1'b1;
            book_len_nxt = book_len_r + LEN_W'(1);
          end
        end
        MODE_START: begin
          if ((start_pos_r != 11'd0) && ({{(LEN_W+1-11){1'b0}}, start_m1} <
                                          {1'b0, book_len_r})) begin
            key_pos_nxt = start_m1[ADDR_W-1:0];
          end else begin
            key_pos_nxt = '0;
          end
        end
        MODE_TEXT: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = in_char_in;
          out_miss_nxt  = 1'b0;
          if (ch_letter) begin
            if (book_len_r == '0) begin
              out_miss_nxt = 1'b1;
            end else begin
              out_char_nxt = ASCII_UC_A + {3'd0, shifted};
              key_pos_nxt  = (pos_inc == {1'b0, book_len_r}) ? '0 : pos_inc[ADDR_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      book_len_r  <= '0;
      key_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      book_len_r  <= book_len_nxt;
      key_pos_r   <= key_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_miss_r <= out_miss_nxt;
  end

  // key book, read address follows the next key position
  rklc_book u_book (
    .clk        (clk),
    .wr         (book_wr),
    .rd_addr    (key_pos_nxt),
    .key_letter (key_letter)
  );

  // key position always points inside a loaded book
  a_pos_in_book: assert property (@(posedge clk) disable iff (!rst_n)
    (book_len_r != '0) |-> ({{(LEN_W-ADDR_W){1'b0}}, key_pos_r} < book_len_r))
    else $error("key position beyond book length");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    book_len_r <= LEN_W'(BOOK_DEPTH))
    else $error("book length beyond depth");

  a_text_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_TEXT)) |=> out_valid_r)
    else $error("text word gave no result");

  a_missing_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_miss_r) |-> is_letter(out_char_r))
    else $error("key missing flagged on a non-letter");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode != MODE_TEXT) && !out_valid_r) |=> !out_valid_r)
    else $error("result from a word that gives none");

endmodule
